>>> design/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Types, constants and helpers for the timestamped location interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam logic [31:0] STALE_RESET = 32'd1000;

  localparam logic [1:0] SRC_INTERP  = 2'd0;
  localparam logic [1:0] SRC_NEAREST = 2'd1;
  localparam logic [1:0] SRC_NONE    = 2'd2;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [2:0] FLD_X = 3'd0;
  localparam logic [2:0] FLD_Y = 3'd1;
  localparam logic [2:0] FLD_Z = 3'd2;
  localparam logic [2:0] FLD_H = 3'd3;
  localparam logic [2:0] FLD_V = 3'd4;

  typedef struct packed {
    logic [47:0]        stamp;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] h;
    logic signed [31:0] v;
  } sample_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_RDA,
    S_RDB,
    S_RDW,
    S_MUL,
    S_DIV,
    S_STORE,
    S_RDN,
    S_NEAR,
    S_EMIT
  } state_t;

  function automatic logic [47:0] abs_diff(input logic [47:0] a, input logic [47:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic signed [31:0] field_of(input sample_t s, input logic [2:0] k);
    case (k)
      FLD_X:   field_of = s.x;
      FLD_Y:   field_of = s.y;
      FLD_Z:   field_of = s.z;
      FLD_H:   field_of = s.h;
      default: field_of = s.v;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/timestamped_location_interpolator_top.sv
// ----------------------------------------------------------------------------
// timestamped_location_interpolator_top
// Ring store of timestamped position samples with nearest/interpolated query.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): in_mode 0 pushes a sample into the ring at
// the write pointer and gives no result; in_mode 1 queries the position at
// in_stamp and gives exactly one result on the out_ channel.
// A push writes the ring directly. A query scans the filled entries through the
// single sample memory read port, one entry a cycle (a ring of one entry skips
// the scan), then for an interpolated answer reads the two chosen samples and
// runs one shared 32x32 multiplier and a radix-2 restoring divider over the
// five values in turn; a nearest neighbour answer reads one chosen sample.
// in_stall is high for the whole query.
// The result sits in an output register; a new item may be taken while it
// waits, but a finished query holds until the register frees.
// Reset (rst_n, synchronous) empties the ring and sets stale_limit_ms to 1000;
// sample memory contents are not cleared. cfg_wr_en writes stale_limit_ms
// and is only to be used while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_location_interpolator_top #(
  parameter int unsigned DEPTH = tli_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic [47:0]        in_stamp,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_horiz_precision,
  input  wire logic signed [31:0] in_vert_precision,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_horiz_precision,
  output logic signed [31:0]      out_vert_precision,
  output logic [1:0]              out_source
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  tli_pkg::state_t state_r, state_nxt;

  tli_pkg::sample_t mem_r [DEPTH];
  tli_pkg::sample_t rd_data_r;
  tli_pkg::sample_t samp_a_r, samp_b_r;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  logic [AW-1:0] wr_idx_r;
  logic [FW-1:0] filled_r;
  logic [31:0]   stale_r;
  logic [47:0]   q_r;

  logic [FW-1:0] scan_cnt_r;
  logic          pend_r;
  logic [AW-1:0] pend_idx_r;

  logic          b0_ok_r, b1_ok_r;
  logic [30:0]   b0_d_r, b1_d_r;
  logic [AW-1:0] b0_idx_r, b1_idx_r;
  logic [47:0]   b0_st_r, b1_st_r;

  logic [AW-1:0] a_idx_r, b_idx_r, near_idx_r;
  logic [31:0]   span_r, dx_r;
  logic          interp_ok;

  logic [2:0]    fidx_r;
  logic [4:0]    step_r;
  logic [31:0]   rem_r, low_r;
  logic          neg_r;

  logic signed [31:0] res_r [5];
  logic [1:0]         src_r;
  logic               out_valid_r;

  logic               accept;
  logic               scan_done;
  logic [47:0]        scan_d48;
  logic               scan_hit;
  logic [47:0]        ta, tb;
  logic               a_is_b1;
  logic signed [31:0] v0, v1;
  logic signed [32:0] delta;
  logic [31:0]        mag;
  logic [32:0]        div_t;
  logic               div_ge;
  logic signed [31:0] lerp;
  logic signed [31:0] flagged;
  logic [47:0]        near_d;
  logic               stale;

  assign accept    = in_valid && !in_stall;
  assign scan_done = (scan_cnt_r == filled_r) && !pend_r;
  assign scan_d48  = tli_pkg::abs_diff(rd_data_r.stamp, q_r);
  assign scan_hit  = (scan_d48[47:31] == 17'd0);

  assign a_is_b1   = (b0_st_r > b1_st_r);
  assign ta        = a_is_b1 ? b1_st_r : b0_st_r;
  assign tb        = a_is_b1 ? b0_st_r : b1_st_r;
  assign interp_ok = (ta <= q_r) && (q_r <= tb);

  assign v0    = tli_pkg::field_of(samp_a_r, fidx_r);
  assign v1    = tli_pkg::field_of(samp_b_r, fidx_r);
  assign delta = {v1[31], v1} - {v0[31], v0};
  assign mag   = delta[32] ? 32'(-delta) : delta[31:0];

  assign div_t  = {rem_r, low_r[31]};
  assign div_ge = (div_t >= {1'b0, span_r});

  assign lerp = neg_r ? (v0 - $signed(low_r)) : (v0 + $signed(low_r));
  // flag an interpolated precision when either end was flagged
  assign flagged = ((fidx_r == tli_pkg::FLD_H || fidx_r == tli_pkg::FLD_V) && !lerp[31] &&
                    (samp_a_r.h[31] && fidx_r == tli_pkg::FLD_H ||
                     samp_b_r.h[31] && fidx_r == tli_pkg::FLD_H ||
                     samp_a_r.v[31] && fidx_r == tli_pkg::FLD_V ||
                     samp_b_r.v[31] && fidx_r == tli_pkg::FLD_V)) ? -lerp : lerp;

  assign near_d = tli_pkg::abs_diff(rd_data_r.stamp, q_r);
  assign stale  = (near_d > {16'd0, stale_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tli_pkg::S_IDLE: begin
        if (accept && in_mode != tli_pkg::MODE_PUSH) begin
          state_nxt = (filled_r == FW'(1)) ? tli_pkg::S_RDN : tli_pkg::S_SCAN;
        end
      end
      tli_pkg::S_SCAN: begin
        if (scan_done) state_nxt = tli_pkg::S_PICK;
      end
      tli_pkg::S_PICK: begin
        if (!(b0_ok_r && b1_ok_r)) state_nxt = tli_pkg::S_EMIT;
        else if (interp_ok)        state_nxt = tli_pkg::S_RDA;
        else                       state_nxt = tli_pkg::S_RDN;
      end
      tli_pkg::S_RDA:   state_nxt = tli_pkg::S_RDB;
      tli_pkg::S_RDB:   state_nxt = tli_pkg::S_RDW;
      tli_pkg::S_RDW:   state_nxt = tli_pkg::S_MUL;
      tli_pkg::S_MUL:   state_nxt = (span_r == 32'd0) ? tli_pkg::S_STORE : tli_pkg::S_DIV;
      tli_pkg::S_DIV: begin
        if (step_r == 5'd31) state_nxt = tli_pkg::S_STORE;
      end
      tli_pkg::S_STORE: begin
        state_nxt = (fidx_r == tli_pkg::FLD_V) ? tli_pkg::S_EMIT : tli_pkg::S_MUL;
      end
      tli_pkg::S_RDN:   state_nxt = tli_pkg::S_NEAR;
      tli_pkg::S_NEAR:  state_nxt = tli_pkg::S_EMIT;
      tli_pkg::S_EMIT: begin
        if (!out_valid_r) state_nxt = tli_pkg::S_IDLE;
      end
      default: state_nxt = tli_pkg::S_IDLE;
    endcase
  end

  // handshake and memory control
  always_comb begin
    in_stall = (state_r != tli_pkg::S_IDLE);
    mem_we   = accept && (in_mode == tli_pkg::MODE_PUSH);
    case (state_r)
      tli_pkg::S_SCAN: rd_addr = scan_cnt_r[AW-1:0];
      tli_pkg::S_RDA:  rd_addr = a_idx_r;
      tli_pkg::S_RDB:  rd_addr = b_idx_r;
      tli_pkg::S_RDN:  rd_addr = near_idx_r;
      default:         rd_addr = a_idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_idx_r] <= '{stamp: in_stamp, x: in_pos_x, y: in_pos_y, z: in_pos_z,
                           h: in_horiz_precision, v: in_vert_precision};
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tli_pkg::S_IDLE;
      wr_idx_r    <= '0;
      filled_r    <= '0;
      stale_r     <= tli_pkg::STALE_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      b0_ok_r     <= 1'b0;
      b1_ok_r     <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) stale_r <= cfg_wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        tli_pkg::S_IDLE: begin
          if (mem_we) begin
            wr_idx_r <= (wr_idx_r == AW'(DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
            if (filled_r != FW'(DEPTH)) filled_r <= filled_r + 1'b1;
          end
          if (accept) begin
            q_r        <= in_stamp;
            near_idx_r <= '0;
            scan_cnt_r <= '0;
            pend_r     <= 1'b0;
            b0_ok_r    <= 1'b0;
            b1_ok_r    <= 1'b0;
          end
        end
        tli_pkg::S_SCAN: begin
          pend_r     <= (scan_cnt_r != filled_r);
          pend_idx_r <= scan_cnt_r[AW-1:0];
          if (scan_cnt_r != filled_r) scan_cnt_r <= scan_cnt_r + 1'b1;
          // keep the two closest matches, earlier index winning ties
          if (pend_r && scan_hit) begin
            if (!b0_ok_r || scan_d48[30:0] < b0_d_r) begin
              b1_ok_r  <= b0_ok_r;
              b1_d_r   <= b0_d_r;
              b1_idx_r <= b0_idx_r;
              b1_st_r  <= b0_st_r;
              b0_ok_r  <= 1'b1;
              b0_d_r   <= scan_d48[30:0];
              b0_idx_r <= pend_idx_r;
              b0_st_r  <= rd_data_r.stamp;
            end else if (!b1_ok_r || scan_d48[30:0] < b1_d_r) begin
              b1_ok_r  <= 1'b1;
              b1_d_r   <= scan_d48[30:0];
              b1_idx_r <= pend_idx_r;
              b1_st_r  <= rd_data_r.stamp;
            end
          end
        end
        tli_pkg::S_PICK: begin
          a_idx_r    <= a_is_b1 ? b1_idx_r : b0_idx_r;
          b_idx_r    <= a_is_b1 ? b0_idx_r : b1_idx_r;
          near_idx_r <= b0_idx_r;
          span_r     <= 32'(tb - ta);
          dx_r       <= 32'(q_r - ta);
          fidx_r     <= tli_pkg::FLD_X;
          if (!(b0_ok_r && b1_ok_r)) begin
            res_r[0] <= '0;
            res_r[1] <= '0;
            res_r[2] <= '0;
            res_r[3] <= -32'sd1;
            res_r[4] <= -32'sd1;
            src_r    <= tli_pkg::SRC_NONE;
          end else begin
            src_r <= tli_pkg::SRC_INTERP;
          end
        end
        tli_pkg::S_RDB: samp_a_r <= rd_data_r;
        tli_pkg::S_RDW: samp_b_r <= rd_data_r;
        tli_pkg::S_MUL: begin
          {rem_r, low_r} <= (span_r == 32'd0) ? 64'd0 : 64'(mag) * 64'(dx_r);
          neg_r          <= delta[32];
          step_r         <= '0;
        end
        tli_pkg::S_DIV: begin
          rem_r  <= div_ge ? 32'(div_t - {1'b0, span_r}) : div_t[31:0];
          low_r  <= {low_r[30:0], div_ge};
          step_r <= step_r + 1'b1;
        end
        tli_pkg::S_STORE: begin
          res_r[fidx_r] <= flagged;
          fidx_r        <= fidx_r + 1'b1;
        end
        tli_pkg::S_NEAR: begin
          res_r[0] <= rd_data_r.x;
          res_r[1] <= rd_data_r.y;
          res_r[2] <= rd_data_r.z;
          res_r[3] <= (stale && rd_data_r.h > 0) ? -rd_data_r.h : rd_data_r.h;
          res_r[4] <= (stale && rd_data_r.v > 0) ? -rd_data_r.v : rd_data_r.v;
          src_r    <= tli_pkg::SRC_NEAREST;
        end
        tli_pkg::S_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r         <= 1'b1;
            out_x               <= res_r[0];
            out_y               <= res_r[1];
            out_z               <= res_r[2];
            out_horiz_precision <= res_r[3];
            out_vert_precision  <= res_r[4];
            out_source          <= src_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tli_pkg::S_EMIT))
    else $error("result transfer raised outside emit");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= FW'(DEPTH))
    else $error("fill count beyond depth");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    b1_ok_r |-> b0_ok_r)
    else $error("second match held without a first");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tli_pkg::S_DIV |-> rem_r < span_r)
    else $error("divider remainder not below span");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Location interpolator testbench
// Pushes timestamped samples and queries positions through the valid/stall
// channels, predicts each query answer from a local copy of the ring and the
// stale limit, and compares every field of each result in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = int'(tli_pkg::DEPTH_DEF);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [47:0] in_stamp = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_horiz_precision = '0, in_vert_precision = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z, out_horiz_precision, out_vert_precision;
  logic [1:0] out_source;

  always #4 clk = ~clk;

  timestamped_location_interpolator_top dut (.*);

  typedef struct packed {
    logic signed [31:0] x, y, z, h, v;
    logic [1:0] src;
  } fix_t;

  // local copy of the ring
  tli_pkg::sample_t ring [RING];
  int unsigned wr_ptr, fill;
  logic [31:0] stale_ms;

  fix_t fixes_due[$];
  int errors = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [47:0] tgap(input logic [47:0] a, input logic [47:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic signed [31:0] lerp(input logic signed [31:0] v0,
      input logic signed [31:0] v1, input logic [47:0] dx, input logic [47:0] span);
    logic signed [63:0] delta;
    logic [127:0] mag, q;
    if (span == 0) return v0;
    delta = 64'(v1) - 64'(v0);
    mag = (delta < 0) ? 128'(-delta) : 128'(delta);
    q = (mag * dx) / span;
    return (delta < 0) ? 32'(64'(v0) - 64'(q)) : 32'(64'(v0) + 64'(q));
  endfunction

  function automatic logic signed [31:0] taint(input logic signed [31:0] r,
      input logic signed [31:0] a, input logic signed [31:0] b);
    return (r >= 0 && (a < 0 || b < 0)) ? -r : r;
  endfunction

  function automatic int closest(input logic [47:0] q, input int skip, output logic [47:0] best);
    logic [47:0] lim = 48'h8000_0000;
    int idx = -1;
    for (int i = 0; i < fill; i++) begin
      if (i != skip && tgap(ring[i].stamp, q) < lim) begin
        lim = tgap(ring[i].stamp, q);
        idx = i;
      end
    end
    best = lim;
    return idx;
  endfunction

  function automatic fix_t nearest_fix(input int i, input logic [47:0] q);
    fix_t f;
    f = '{ring[i].x, ring[i].y, ring[i].z, ring[i].h, ring[i].v, tli_pkg::SRC_NEAREST};
    if (tgap(ring[i].stamp, q) > {16'd0, stale_ms}) begin
      if (f.h > 0) f.h = -f.h;
      if (f.v > 0) f.v = -f.v;
    end
    return f;
  endfunction

  // apply one item to the local ring; queries return their answer
  function automatic bit locate(input logic mode, input tli_pkg::sample_t s, output fix_t f);
    int i0, i1, a, b;
    logic [47:0] d0, d1, dx, span;
    f = '0;
    if (mode == tli_pkg::MODE_PUSH) begin
      ring[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % RING;
      if (fill < RING) fill++;
      return 0;
    end
    if (fill == 1) begin
      f = nearest_fix(0, s.stamp);
      return 1;
    end
    i0 = closest(s.stamp, -1, d0);
    i1 = (i0 < 0) ? -1 : closest(s.stamp, i0, d1);
    if (i0 < 0 || i1 < 0) begin
      f = '{32'sd0, 32'sd0, 32'sd0, -32'sd1, -32'sd1, tli_pkg::SRC_NONE};
      return 1;
    end
    a = i0; b = i1;
    if (ring[i0].stamp > ring[i1].stamp) begin a = i1; b = i0; end
    if (ring[a].stamp <= s.stamp && s.stamp <= ring[b].stamp) begin
      dx = s.stamp - ring[a].stamp;
      span = ring[b].stamp - ring[a].stamp;
      f.x = lerp(ring[a].x, ring[b].x, dx, span);
      f.y = lerp(ring[a].y, ring[b].y, dx, span);
      f.z = lerp(ring[a].z, ring[b].z, dx, span);
      f.h = taint(lerp(ring[a].h, ring[b].h, dx, span), ring[a].h, ring[b].h);
      f.v = taint(lerp(ring[a].v, ring[b].v, dx, span), ring[a].v, ring[b].v);
      f.src = tli_pkg::SRC_INTERP;
      return 1;
    end
    f = nearest_fix((d0 <= d1) ? i0 : i1, s.stamp);
    return 1;
  endfunction

  // valid stays high after a transfer until the next item or an idle call
  task automatic send(input logic mode, input tli_pkg::sample_t s);
    fix_t f;
    int unsigned gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_stamp <= s.stamp;
    in_pos_x <= s.x; in_pos_y <= s.y; in_pos_z <= s.z;
    in_horiz_precision <= s.h; in_vert_precision <= s.v;
    do @(posedge clk); while (in_stall);
    if (locate(mode, s, f)) fixes_due.push_back(f);
    @(negedge clk);
  endtask

  // drop valid and wait until every query answer has been taken
  task automatic drain();
    in_valid <= 1'b0;
    wait (fixes_due.size() == 0);
    @(negedge clk);
  endtask

  task automatic set_stale(input logic [31:0] ms);
    drain();
    repeat (300) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ms;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    stale_ms = ms;
  endtask

  function automatic tli_pkg::sample_t rand_sample(input logic [47:0] stamp);
    tli_pkg::sample_t s;
    s.stamp = stamp;
    s.x = $urandom; s.y = $urandom; s.z = $urandom;
    s.h = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50000);
    s.v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50000);
    return s;
  endfunction

  // directed rows: mode, stamp, x, y, z, h, v, check-typed-result, result
  typedef struct {
    logic mode;
    tli_pkg::sample_t s;
    bit typed;
    fix_t want;
  } row_t;

  row_t rows [] = '{
    '{tli_pkg::MODE_QUERY, '{48'd5, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, -1, -1, tli_pkg::SRC_NONE}},
    '{tli_pkg::MODE_PUSH, '{48'd1000, 32'sh7fffffff, -32'sh80000000, 5, 100, 200}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'hffff_ffff_ffff, 0, 0, 0, 0, 0}, 1,
        '{32'sh7fffffff, -32'sh80000000, 5, -100, -200, tli_pkg::SRC_NEAREST}},
    '{tli_pkg::MODE_QUERY, '{48'd1500, 0, 0, 0, 0, 0}, 1,
        '{32'sh7fffffff, -32'sh80000000, 5, 100, 200, tli_pkg::SRC_NEAREST}},
    '{tli_pkg::MODE_PUSH, '{48'd2000, -32'sh80000000, 32'sh7fffffff, -7, -4, 300}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd1500, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd1000, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd2000, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd9000, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd0, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'hffff_ffff_ffff, 0, 0, 0, 0, 0}, 1,
        '{0, 0, 0, -1, -1, tli_pkg::SRC_NONE}},
    '{tli_pkg::MODE_PUSH, '{48'd2000, 11, 22, 33, 44, 55}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd2000, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'd1999, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_PUSH, '{48'h8000_1000, 1, 2, 3, 4, 5}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'h8000_07d0, 0, 0, 0, 0, 0}, 0, '0},
    '{tli_pkg::MODE_QUERY, '{48'h4000_0000, 0, 0, 0, 0, 0}, 0, '0}
  };

  initial begin
    logic [47:0] base;
    stale_ms = tli_pkg::STALE_RESET;
    wr_ptr = 0; fill = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[r]) begin
      if (rows[r].typed) begin
        drain();
        send(rows[r].mode, rows[r].s);
        fixes_due[$] = rows[r].want;
      end else begin
        send(rows[r].mode, rows[r].s);
      end
    end
    // random phases over several stale limits, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: set_stale(32'd0);
        2: set_stale(32'hffff_ffff);
        3: set_stale($urandom_range(1, 5000));
        4: set_stale($urandom);
        default: ;
      endcase
      base = 48'({$urandom, $urandom});
      if (phase == 5) base = 48'hffff_ff00_0000;
      for (int k = 0; k < 50; k++) begin
        if (phase == 2 && k == 20) hold_off = 1;
        if ($urandom_range(0, 9) < 5) begin
          base = 48'(base + $urandom_range(0, 2000));
          send(tli_pkg::MODE_PUSH, rand_sample(base));
        end else if ($urandom_range(0, 9) == 0) begin
          send(tli_pkg::MODE_QUERY, rand_sample(48'({$urandom, $urandom})));
        end else begin
          send(tli_pkg::MODE_QUERY,
               rand_sample(48'(base - $urandom_range(0, 6000) + $urandom_range(0, 3000))));
        end
      end
    end
    // overwrite the whole ring at least once
    for (int k = 0; k < 300; k++) begin
      base = 48'(base + $urandom_range(1, 50));
      if (k % 10 == 9)
        send(tli_pkg::MODE_QUERY, rand_sample(48'(base - 20)));
      else
        send(tli_pkg::MODE_PUSH, rand_sample(base));
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random wait before each transfer plus one long hold-off
  initial begin
    int unsigned gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 15);
      if (hold_off) begin
        gap = 2000;
        hold_off = 0;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    fix_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (fixes_due.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = fixes_due.pop_front();
        if (out_x !== w.x) report("out_x", out_x, w.x);
        if (out_y !== w.y) report("out_y", out_y, w.y);
        if (out_z !== w.z) report("out_z", out_z, w.z);
        if (out_horiz_precision !== w.h) report("out_horiz_precision", out_horiz_precision, w.h);
        if (out_vert_precision !== w.v) report("out_vert_precision", out_vert_precision, w.v);
        if (out_source !== w.src) report("out_source", out_source, w.src);
      end
    end
  end

  initial begin
    wait (stim_done && fixes_due.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
